// ===== sv/mpc_pkg.sv =====
// ----------------------------------------------------------------------------
// mpc_pkg
// shared types, constants and helpers for the mandelbrot pixel engine
// ----------------------------------------------------------------------------
`default_nettype none

package mpc_pkg;

  // default bounds for the top level parameters
  localparam int unsigned MAX_DIM_DEF    = 4096;
  localparam int unsigned ITER_LIMIT_DEF = 4096;

  // port widths
  localparam int unsigned CFG_W      = 13;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned INTENS_W   = 8;
  localparam int unsigned ADDR_W     = 24;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_MAX_ITER     = 2'd2
  } cfg_reg_e;

  localparam logic [CFG_W-1:0] WIDTH_RST    = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RST   = 13'd480;
  localparam logic [CFG_W-1:0] MAX_ITER_RST = 13'd256;

  // divider geometry
  localparam int unsigned DIV_NUM_W     = 32;
  localparam int unsigned DIV_DEN_W_DEF = 13;

  // q5.27 constants
  localparam int unsigned FRAC = 27;
  localparam logic [DIV_NUM_W-1:0] STEP_R_NUM = 32'd402653184;   // 3.0 in q5.27
  localparam logic [DIV_NUM_W-1:0] STEP_I_NUM = 32'd469762048;   // 3.5 in q5.27
  localparam logic signed [31:0]   ORIGIN_R   = -32'sd268435456; // -2.0
  localparam logic signed [31:0]   ORIGIN_I   = -32'sd234881024; // -1.75
  localparam logic [63:0]          ESC_LIM    = 64'h0100_0000_0000_0000; // 4.0 in q10.54

  localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

  // clip a wide signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] res;
    if (v > SAT_HI) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < SAT_LO) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== sv/mandelbrot_pixel_conv_detect.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_pixel_conv_detect
// escape-time pixel engine with convergence detection, q5.27 arithmetic
// ----------------------------------------------------------------------------
// usage:
//   command channel: drive pixel_column_i / pixel_row_i and pulse start_i;
//   the word is taken on a clock edge with start_i high and busy_o low.
//   busy_o stays high until the result is out.
//   result channel: done_o is high for exactly one cycle with intensity_o
//   and pixel_address_o; the receiver cannot stall it, so it must take it.
//   config channel: cfg_valid_i / cfg_ready_o with cfg_addr_i and cfg_data_i
//   (0 image_width, 1 image_height, 2 max_iter); ready is always high.
//   write config only while busy_o is low.
// sequence:
//   two divisions for the plane steps, a prologue of 5 multiplies, then
//   the iterations on the one shared multiplier, then one more division
//   to scale the count when the intensity is not forced to 0. the next
//   command is taken at the earliest at the edge ending the done_o cycle.
//   one pixel at a time.
// reset: config registers return to 640 / 480 / 256, the engine goes idle.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_pixel_conv_detect #(
  parameter int unsigned MAX_DIM    = mpc_pkg::MAX_DIM_DEF,
  parameter int unsigned ITER_LIMIT = mpc_pkg::ITER_LIMIT_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // command channel
  input  wire logic                            start_i,
  output logic                                 busy_o,
  input  wire logic [mpc_pkg::COORD_W-1:0]     pixel_column_i,
  input  wire logic [mpc_pkg::COORD_W-1:0]     pixel_row_i,
  // result channel
  output logic                                 done_o,
  output logic [mpc_pkg::INTENS_W-1:0]         intensity_o,
  output logic [mpc_pkg::ADDR_W-1:0]           pixel_address_o,
  // config channel
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [mpc_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  wire logic [mpc_pkg::CFG_W-1:0]       cfg_data_i
);

  localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1);
  localparam int unsigned LIM_W  = $clog2(ITER_LIMIT + 1);
  localparam int unsigned DEN_W  = (DIM_W > LIM_W) ? DIM_W : LIM_W;
  localparam int unsigned CONV_W = LIM_W + 2;
  localparam int unsigned C20_W  = CONV_W + 5;
  localparam int unsigned NUM_W  = mpc_pkg::DIV_NUM_W;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DIV_R,   // real step division
    S_DIV_I,   // imaginary step division, col*step_r in flight
    S_M_CI,    // form cr, issue row*step_i
    S_M_AD,    // form ci, issue row*width
    S_P_RR,    // form address, issue r*r
    S_P_II,    // take r*r, issue i*i
    S_P_FIN,   // take i*i
    S_RI,      // next real part, issue r*i
    S_NI,      // next imaginary part
    S_DR,      // issue dr*dr
    S_DI,      // issue di*di
    S_RR,      // sum distance, issue r*r
    S_II,      // convergence counter, issue i*i
    S_CHK,     // stop tests
    S_DIV_O    // scale count to a byte
  } state_e;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [mpc_pkg::CFG_W-1:0] width_q, height_q, max_iter_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= mpc_pkg::WIDTH_RST;
      height_q   <= mpc_pkg::HEIGHT_RST;
      max_iter_q <= mpc_pkg::MAX_ITER_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (mpc_pkg::cfg_reg_e'(cfg_addr_i))
        mpc_pkg::REG_IMAGE_WIDTH:  width_q    <= cfg_data_i;
        mpc_pkg::REG_IMAGE_HEIGHT: height_q   <= cfg_data_i;
        mpc_pkg::REG_MAX_ITER:     max_iter_q <= cfg_data_i;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // clamped dimensions and limit: zero size acts as one, oversize saturates
  logic [DIM_W-1:0] w_cfg, h_cfg;
  logic [LIM_W-1:0] lim_cfg;

  always_comb begin
    if (width_q == '0) begin
      w_cfg = DIM_W'(1);
    end else if (32'(width_q) > MAX_DIM) begin
      w_cfg = DIM_W'(MAX_DIM);
    end else begin
      w_cfg = DIM_W'(width_q);
    end
    if (height_q == '0) begin
      h_cfg = DIM_W'(1);
    end else if (32'(height_q) > MAX_DIM) begin
      h_cfg = DIM_W'(MAX_DIM);
    end else begin
      h_cfg = DIM_W'(height_q);
    end
    if (32'(max_iter_q) > ITER_LIMIT) begin
      lim_cfg = LIM_W'(ITER_LIMIT);
    end else begin
      lim_cfg = LIM_W'(max_iter_q);
    end
  end

  // ---------------------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------------------
  state_e state_q;

  logic [mpc_pkg::COORD_W-1:0] col_q, row_q;
  logic [DIM_W-1:0]            w_q, h_q;
  logic [LIM_W-1:0]            lim_q;
  logic signed [31:0]          step_r_q, step_i_q;
  logic signed [31:0]          cr_q, ci_q, r_q, i_q, old_r_q, old_i_q, nr_q;
  logic [63:0]                 rr_q, ii_q, d_q, old_d_q;
  logic signed [CONV_W-1:0]    conv_q;
  logic [LIM_W-1:0]            cnt_q;
  logic                        done_q;
  logic [mpc_pkg::INTENS_W-1:0] intensity_q;
  logic [mpc_pkg::ADDR_W-1:0]   addr_q;

  // shared multiplier
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic [63:0]        mul_pu;

  mpc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign mul_pu = mul_p;

  // iterative divider
  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0] div_den;

  mpc_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // ---------------------------------------------------------------------------
  // combinational helpers
  // ---------------------------------------------------------------------------
  logic                     accept;
  logic signed [31:0]       dr, di, cr_new, ci_new, nr_new, ni_new;
  logic signed [64:0]       sq_diff;
  logic [63:0]              esc_sum;
  logic                     esc, brk;
  logic signed [C20_W-1:0]  conv20, lim_s;
  logic signed [CONV_W-1:0] conv_d;
  logic [LIM_W-1:0]         fin;
  logic                     need_scale;

  assign accept = start_i && (state_q == S_IDLE);

  always_comb begin
    // step differences for the distance term
    dr = mpc_pkg::sat32(66'(r_q) - 66'(old_r_q));
    di = mpc_pkg::sat32(66'(i_q) - 66'(old_i_q));
    // plane origin plus pixel offset
    cr_new = mpc_pkg::sat32(66'(mul_p) + 66'(mpc_pkg::ORIGIN_R));
    ci_new = mpc_pkg::sat32(66'(mul_p) + 66'(mpc_pkg::ORIGIN_I));
    // z^2 + c, products floored back to q5.27
    sq_diff = $signed({1'b0, rr_q}) - $signed({1'b0, ii_q});
    nr_new  = mpc_pkg::sat32(66'(sq_diff >>> mpc_pkg::FRAC) + 66'(cr_q));
    ni_new  = mpc_pkg::sat32(66'(mul_p >>> (mpc_pkg::FRAC - 1)) + 66'(ci_q));
    // convergence counter: up when the step shrinks, down when it grows
    conv_d = conv_q;
    if (d_q < old_d_q) begin
      conv_d = conv_q + CONV_W'(1);
    end else if (d_q > old_d_q) begin
      conv_d = conv_q - CONV_W'(1);
    end
    // stop tests, with i*i arriving from the multiplier
    esc_sum = rr_q + mul_pu;
    esc     = (esc_sum > mpc_pkg::ESC_LIM);
    conv20  = (C20_W'(conv_q) <<< 4) + (C20_W'(conv_q) <<< 2);
    lim_s   = $signed(C20_W'(lim_q));
    brk     = esc || (cnt_q == lim_q) || (conv20 > lim_s);
    fin     = (conv20 < lim_s) ? cnt_q : '0;
    need_scale = (fin != lim_q);
  end

  // divider operand select
  always_comb begin
    div_num   = '0;
    div_den   = '0;
    div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        div_num   = mpc_pkg::STEP_R_NUM;
        div_den   = DEN_W'(w_cfg);
        div_start = start_i;
      end
      S_DIV_R: begin
        div_num   = mpc_pkg::STEP_I_NUM;
        div_den   = DEN_W'(h_q);
        div_start = div_done;
      end
      S_CHK: begin
        // count * 255 as a shift and subtract
        div_num   = NUM_W'({fin, 8'h00}) - NUM_W'(fin);
        div_den   = DEN_W'(lim_q);
        div_start = brk && need_scale;
      end
      default: ;
    endcase
  end

  // multiplier operand select
  always_comb begin
    mul_a = r_q;
    mul_b = i_q;
    case (state_q)
      S_DIV_I: begin
        mul_a = 32'(col_q);
        mul_b = step_r_q;
      end
      S_M_CI: begin
        mul_a = 32'(row_q);
        mul_b = step_i_q;
      end
      S_M_AD: begin
        mul_a = 32'(row_q);
        mul_b = 32'(w_q);
      end
      S_P_RR, S_RR: begin
        mul_a = r_q;
        mul_b = r_q;
      end
      S_P_II, S_II: begin
        mul_a = i_q;
        mul_b = i_q;
      end
      S_DR: begin
        mul_a = dr;
        mul_b = dr;
      end
      S_DI: begin
        mul_a = di;
        mul_b = di;
      end
      default: ;  // r*i
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer with result registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      done_q      <= 1'b0;
      intensity_q <= '0;
      addr_q      <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE:  if (start_i) state_q <= S_DIV_R;
        S_DIV_R: if (div_done) state_q <= S_DIV_I;
        S_DIV_I: if (div_done) state_q <= S_M_CI;
        S_M_CI:  state_q <= S_M_AD;
        S_M_AD:  state_q <= S_P_RR;
        S_P_RR: begin
          addr_q  <= mpc_pkg::ADDR_W'(mul_pu) + mpc_pkg::ADDR_W'(col_q);
          state_q <= S_P_II;
        end
        S_P_II:  state_q <= S_P_FIN;
        S_P_FIN: state_q <= S_RI;
        S_RI:    state_q <= S_NI;
        S_NI:    state_q <= S_DR;
        S_DR:    state_q <= S_DI;
        S_DI:    state_q <= S_RR;
        S_RR:    state_q <= S_II;
        S_II:    state_q <= S_CHK;
        S_CHK: begin
          if (!brk) begin
            state_q <= S_RI;
          end else if (need_scale) begin
            state_q <= S_DIV_O;
          end else begin
            // count at the limit or zeroed by convergence at a zero limit
            intensity_q <= '0;
            done_q      <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_DIV_O: begin
          if (div_done) begin
            intensity_q <= div_quo[mpc_pkg::INTENS_W-1:0];
            done_q      <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload registers, loaded per state
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          col_q   <= pixel_column_i;
          row_q   <= pixel_row_i;
          w_q     <= w_cfg;
          h_q     <= h_cfg;
          lim_q   <= lim_cfg;
          cnt_q   <= '0;
          conv_q  <= '0;
          old_d_q <= '0;
        end
      end
      S_DIV_R: if (div_done) step_r_q <= div_quo;
      S_DIV_I: if (div_done) step_i_q <= div_quo;
      S_M_CI:  cr_q <= cr_new;
      S_M_AD: begin
        ci_q    <= ci_new;
        r_q     <= cr_q;
        old_r_q <= cr_q;
      end
      S_P_RR: begin
        i_q     <= ci_q;
        old_i_q <= ci_q;
      end
      S_P_II:  rr_q <= mul_pu;
      S_P_FIN: ii_q <= mul_pu;
      S_RI:    nr_q <= nr_new;
      S_NI: begin
        r_q <= nr_q;
        i_q <= ni_new;
      end
      S_DI: d_q <= mul_pu;
      S_RR: d_q <= d_q + mul_pu;
      S_II: begin
        rr_q   <= mul_pu;
        conv_q <= conv_d;
      end
      S_CHK: begin
        ii_q <= mul_pu;
        if (!brk) begin
          cnt_q   <= cnt_q + LIM_W'(1);
          old_r_q <= r_q;
          old_i_q <= i_q;
          old_d_q <= d_q;
        end
      end
      default: ;
    endcase
  end

  assign busy_o          = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign intensity_o     = intensity_q;
  assign pixel_address_o = addr_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // the result strobe only appears once the engine is back to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // an accepted command always makes the engine busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("command accepted but engine not busy");

  // the iteration count never passes the latched limit
  a_cnt_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> (cnt_q <= lim_q))
    else $error("iteration count above limit");

  // a scaled count below the limit never reaches full scale
  a_int_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (intensity_o != 8'hFF))
    else $error("intensity at full scale");

endmodule

`default_nettype wire

// ===== sv/mpc_mul.sv =====
// ----------------------------------------------------------------------------
// mpc_mul
// shared signed 32x32 multiplier with a registered 64-bit product
// ----------------------------------------------------------------------------
`default_nettype none

module mpc_mul (
  input  wire logic               clk_i,
  input  wire logic signed [31:0] a_i,
  input  wire logic signed [31:0] b_i,
  output logic signed [63:0]      p_o
);

  logic signed [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ===== sv/mpc_div.sv =====
// ----------------------------------------------------------------------------
// mpc_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module mpc_div #(
  parameter int unsigned NUM_W = mpc_pkg::DIV_NUM_W,
  parameter int unsigned DEN_W = mpc_pkg::DIV_DEN_W_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic      [NUM_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W:0]   rem_sh, rem_diff;
  logic             ge;

  always_comb begin
    rem_sh   = {rem_q, num_q[NUM_W-1]};
    rem_diff = rem_sh - {1'b0, den_q};
    ge       = (rem_sh >= {1'b0, den_q});
    rem_d    = ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    num_d    = {num_q[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(NUM_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  // quotient bits shift in at the bottom of the dividend register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

`default_nettype wire
